// ===== rtl/sfht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfht_pkg
// shared types and constants of the search frontier hash table
// ----------------------------------------------------------------------------
package sfht_pkg;
    localparam int LOG_ENTRIES_DEF = 10;
    localparam logic [7:0] DRAGONFLY_RESET = 8'd3;
    localparam logic [1:0] SIDE_NONE = 2'd2;
    localparam logic [7:0] ALG_NONE = 8'd255;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_LOOKUP = 3'd1,
        ACT_MARK   = 3'd2,
        ACT_UPDATE = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_EXIST   = 3'd1,
        ST_MISS    = 3'd2,
        ST_FULL    = 3'd3,
        ST_EXHAUST = 3'd4
    } status_t;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_DRAGON = 2'd1;
    localparam logic [1:0] MARK_FWD = 2'd2;

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_READ, S_CHECK, S_OUT
    } state_t;

    // entry word: key, depth, side, alg
    localparam int ENTRY_W = 64 + 16 + 2 + 8;
endpackage

// ===== rtl/sfht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfht_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module sfht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/search_frontier_hash_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_frontier_hash_table_unit
// linear probing hash table of 64-bit keys with priority update rules
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_axis   in   tdata: action, key, depth_in, side, alg, skip; tlast batch_last
// m_axis   out  tdata: status, hit, depth_out, mark; tlast batch_done
// cfg      in   cfg_we / cfg_wdata: dragonfly_code
//
// each request is accepted in the idle state; each probed slot then takes a ram read
// followed by a compare/write, and the result leaves through the output state;
// requests answered without a probe go from the idle state straight to the output.
// after reset and after a clear the table is swept one entry per cycle, over all
// 2^LOG_ENTRIES entries, with s_axis_tready low.
// a result waits in the output register; the next request is taken no earlier
// than the cycle in which that result leaves.
// ----------------------------------------------------------------------------
module search_frontier_hash_table_unit
    import sfht_pkg::*;
#(
    parameter int LOG_ENTRIES = LOG_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], key[66:3], depth_in[82:67], side[83], alg[91:84], skip[92]
    input  logic [95:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], hit[3], depth_out[19:4], mark[21:20]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int N = 1 << LOG_ENTRIES;
    localparam int CW = LOG_ENTRIES + 1;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] HALF = CW'(N / 2);

    state_t state_reg, state_next;
    logic [7:0] dcode_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [LOG_ENTRIES-1:0] idx_reg, idx_next;
    logic [LOG_ENTRIES:0] n_reg, n_next;
    logic [2:0] act_reg;
    logic [63:0] key_reg;
    logic [15:0] din_reg;
    logic side_reg;
    logic [7:0] alg_reg;
    logic last_reg;
    logic ov_reg, ov_next;
    logic [23:0] od_reg, od_next;
    logic ol_reg;

    logic we;
    logic [LOG_ENTRIES-1:0] addr;
    logic [ENTRY_W-1:0] wdata, rdata;

    sfht_ram #(.WIDTH(ENTRY_W), .DEPTH(N)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [63:0] e_key;
    logic [15:0] e_dep;
    logic [1:0] e_side;
    logic [7:0] e_alg;
    assign e_key = rdata[63:0];
    assign e_dep = rdata[79:64];
    assign e_side = rdata[81:80];
    assign e_alg = rdata[89:82];

    logic accept;
    logic out_free;
    assign out_free = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign accept = s_axis_tvalid && s_axis_tready;

    logic [2:0] in_act;
    logic [63:0] in_key;
    assign in_act = s_axis_tdata[2:0];
    assign in_key = s_axis_tdata[66:3];

    function automatic logic [23:0] pack_out(status_t st, logic h, logic [15:0] d,
                                             logic [1:0] m);
        pack_out = {2'b00, m, d, h, st};
    endfunction

    logic [CW-1:0] count_inc;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        priority case (state_reg)
            S_SWEEP: if (idx_reg == LOG_ENTRIES'(N - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    priority if (in_act == ACT_CLEAR) state_next = S_SWEEP;
                    else if (in_act == ACT_UPDATE && s_axis_tdata[92]) state_next = S_IDLE;
                    else if (in_act > ACT_UPDATE || in_key == 64'd0) state_next = S_IDLE;
                    else if (in_act == ACT_INSERT && count_reg >= HALF) state_next = S_IDLE;
                    else state_next = S_READ;
                end
            end
            S_READ: state_next = S_CHECK;
            S_CHECK: begin
                if (e_key != key_reg && e_key != 64'd0 && n_reg != (LOG_ENTRIES+1)'(N - 1))
                    state_next = S_READ;
                else
                    state_next = S_OUT;
            end
            S_OUT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        logic found, empty;
        logic [15:0] nd;
        logic [1:0] ns;
        logic [7:0] na;
        found = e_key == key_reg;
        empty = e_key == 64'd0;
        nd = e_dep;
        ns = e_side;
        na = e_alg;
        we = 1'b0;
        addr = idx_reg;
        wdata = {rdata[89:0]};
        idx_next = idx_reg;
        n_next = n_reg;
        count_next = count_reg;
        ov_next = ov_reg && !m_axis_tready;
        od_next = od_reg;
        unique case (state_reg)
            S_SWEEP: begin
                we = 1'b1;
                wdata = {ALG_NONE, SIDE_NONE, 16'd0, 64'd0};
                idx_next = idx_reg + 1'b1;
                count_next = '0;
            end
            S_IDLE: begin
                idx_next = in_key[63 -: LOG_ENTRIES];
                n_next = '0;
                if (accept) begin
                    priority if (in_act == ACT_CLEAR) begin
                        idx_next = '0;
                        ov_next = 1'b1;
                        od_next = pack_out(ST_NEW, 1'b0, 16'd0, MARK_NONE);
                    end else if (in_act == ACT_UPDATE && s_axis_tdata[92]) begin
                        ov_next = 1'b1;
                        od_next = pack_out(ST_EXIST, 1'b0, 16'd0, MARK_NONE);
                    end else if (in_act > ACT_UPDATE || in_key == 64'd0) begin
                        ov_next = 1'b1;
                        od_next = pack_out(ST_MISS, 1'b0, 16'd0, MARK_NONE);
                    end else if (in_act == ACT_INSERT && count_reg >= HALF) begin
                        ov_next = 1'b1;
                        od_next = pack_out(ST_FULL, 1'b0, 16'd0, MARK_NONE);
                    end
                end
            end
            S_READ: ;
            S_CHECK: begin
                od_next = pack_out(ST_MISS, 1'b0, 16'd0, MARK_NONE);
                if (!found && !empty) begin
                    if (n_reg == (LOG_ENTRIES+1)'(N - 1))
                        od_next = pack_out(ST_EXHAUST, 1'b0, 16'd0, MARK_NONE);
                    else begin
                        idx_next = idx_reg + 1'b1;
                        n_next = n_reg + 1'b1;
                    end
                end else begin
                    unique case (act_reg)
                        ACT_INSERT: begin
                            we = 1'b1;
                            if (empty) begin
                                wdata = {alg_reg, 1'b0, side_reg, din_reg, key_reg};
                                count_next = count_inc;
                                od_next = pack_out(ST_NEW, 1'b0, 16'd0, MARK_NONE);
                            end else begin
                                if (e_alg == dcode_reg) begin
                                    if (side_reg && din_reg < e_dep) nd = din_reg;
                                end else if (e_side == {1'b0, side_reg}) begin
                                    if (din_reg < e_dep) begin
                                        nd = din_reg;
                                        na = alg_reg;
                                    end
                                end else if (e_side != 2'd1) begin
                                    ns = {1'b0, side_reg};
                                    nd = din_reg;
                                    na = alg_reg;
                                end
                                wdata = {na, ns, nd, e_key};
                                od_next = pack_out(ST_EXIST, 1'b0, nd, MARK_NONE);
                            end
                        end
                        ACT_LOOKUP: if (found)
                            od_next = pack_out(ST_EXIST, e_side == {1'b0, side_reg},
                                               e_dep, MARK_NONE);
                        ACT_MARK: if (found)
                            od_next = pack_out(ST_EXIST, 1'b0, e_dep,
                                (e_alg == dcode_reg) ? MARK_DRAGON :
                                (e_side == 2'd0) ? MARK_FWD : MARK_NONE);
                        default: begin
                            we = 1'b1;
                            if (found && e_side == 2'd1) begin
                                nd = (din_reg < e_dep) ? din_reg : e_dep;
                                wdata = {dcode_reg, 2'd1, nd, e_key};
                                od_next = pack_out(ST_EXIST, 1'b0, nd, MARK_NONE);
                            end else begin
                                wdata = {dcode_reg, 2'd1, din_reg, key_reg};
                                count_next = count_inc;
                                od_next = pack_out(ST_NEW, 1'b0, 16'd0, MARK_NONE);
                            end
                        end
                    endcase
                end
            end
            S_OUT: if (out_free) ov_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
            dcode_reg <= DRAGONFLY_RESET;
            count_reg <= '0;
            idx_reg <= '0;
            n_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) dcode_reg <= cfg_wdata;
            count_reg <= count_next;
            idx_reg <= idx_next;
            n_reg <= n_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        od_reg <= od_next;
        if (accept) begin
            act_reg <= in_act;
            key_reg <= in_key;
            din_reg <= s_axis_tdata[82:67];
            side_reg <= s_axis_tdata[83];
            alg_reg <= s_axis_tdata[91:84];
            last_reg <= s_axis_tlast;
        end
        if ((accept && state_next != S_READ) || (state_reg == S_OUT && out_free))
            ol_reg <= accept ? s_axis_tlast : last_reg;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;
    assign m_axis_tlast = ol_reg;

`ifndef SYNTHESIS
    a_no_accept_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SWEEP |-> !s_axis_tready) else $error("accept during sweep");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CHECK && act_reg == ACT_INSERT |-> count_reg < HALF)
        else $error("insert past half full");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for search_frontier_hash_table_unit. A local table
// predicts every result, and each result is checked field by field in order.
// The bench covers all actions, the half-full refusal, full-table probing,
// key zero, clears, the dragonfly code setting, and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import sfht_pkg::*;

    localparam int LOGN = 10;
    localparam int NSLOT = 1 << LOGN;
    localparam int HALF = 1 << (LOGN - 1);
    localparam int CNT_MAX = (2 << LOGN) - 1;
    localparam longint LIMIT = 20000000;

    typedef struct packed {
        logic       done;
        logic [1:0] mark;
        logic [15:0] depth;
        logic       hit;
        logic [2:0] status;
    } answer_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [7:0]  cfg_wdata = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    search_frontier_hash_table_unit #(.LOG_ENTRIES(LOGN)) u_dut (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    // table shadow
    logic [63:0] tbl_key [NSLOT];
    logic [15:0] tbl_depth [NSLOT];
    logic [1:0]  tbl_side [NSLOT];
    logic [7:0]  tbl_alg [NSLOT];
    int          tbl_count;
    logic [7:0]  dragon_code;

    answer_t pending_answers[$];
    int      errors = 0;
    int      n_results = 0;
    int      n_requests = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      recv_hold = 0;
    longint  cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got, want);
    endtask

    function automatic void wipe_table();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_key[i] = '0;
            tbl_depth[i] = '0;
            tbl_side[i] = SIDE_NONE;
            tbl_alg[i] = ALG_NONE;
        end
        tbl_count = 0;
    endfunction

    function automatic void bump_count();
        if (tbl_count < CNT_MAX) tbl_count++;
    endfunction

    // returns 0 found, 1 empty, 2 exhausted
    function automatic int find_slot(input logic [63:0] k, output int slot);
        int idx;
        idx = int'(k >> (64 - LOGN));
        slot = 0;
        for (int n = 0; n < NSLOT; n++) begin
            if (tbl_key[idx] == k) begin
                slot = idx;
                return 0;
            end
            if (tbl_key[idx] == 0) begin
                slot = idx;
                return 1;
            end
            idx = (idx + 1) % NSLOT;
        end
        return 2;
    endfunction

    function automatic answer_t apply_request(input logic [2:0] act, input logic [63:0] k,
                                              input logic [15:0] d, input logic sd,
                                              input logic [7:0] al, input logic sk,
                                              input logic lst);
        answer_t a;
        int s, r;
        a = '0;
        a.status = ST_MISS;
        a.done = lst;
        if (act == ACT_CLEAR) begin
            wipe_table();
            a.status = ST_NEW;
        end else if (act == ACT_UPDATE && sk) begin
            a.status = ST_EXIST;
        end else if (act <= ACT_UPDATE && k != 0) begin
            if (act == ACT_INSERT && tbl_count >= HALF) begin
                a.status = ST_FULL;
            end else begin
                r = find_slot(k, s);
                if (r == 2) begin
                    a.status = ST_EXHAUST;
                end else if (act == ACT_INSERT) begin
                    if (r == 1) begin
                        tbl_key[s] = k;
                        tbl_depth[s] = d;
                        tbl_side[s] = {1'b0, sd};
                        tbl_alg[s] = al;
                        bump_count();
                        a.status = ST_NEW;
                    end else begin
                        if (tbl_alg[s] == dragon_code) begin
                            if (sd && d < tbl_depth[s]) tbl_depth[s] = d;
                        end else if (tbl_side[s] == {1'b0, sd}) begin
                            if (d < tbl_depth[s]) begin
                                tbl_depth[s] = d;
                                tbl_alg[s] = al;
                            end
                        end else if (tbl_side[s] != 2'd1) begin
                            tbl_side[s] = {1'b0, sd};
                            tbl_depth[s] = d;
                            tbl_alg[s] = al;
                        end
                        a.status = ST_EXIST;
                        a.depth = tbl_depth[s];
                    end
                end else if (act == ACT_LOOKUP) begin
                    if (r == 0) begin
                        a.status = ST_EXIST;
                        a.depth = tbl_depth[s];
                        a.hit = (tbl_side[s] == {1'b0, sd});
                    end
                end else if (act == ACT_MARK) begin
                    if (r == 0) begin
                        a.status = ST_EXIST;
                        a.depth = tbl_depth[s];
                        if (tbl_alg[s] == dragon_code) a.mark = MARK_DRAGON;
                        else if (tbl_side[s] == 2'd0) a.mark = MARK_FWD;
                    end
                end else begin
                    if (r == 0 && tbl_side[s] == 2'd1) begin
                        if (d < tbl_depth[s]) tbl_depth[s] = d;
                        tbl_alg[s] = dragon_code;
                        a.status = ST_EXIST;
                        a.depth = tbl_depth[s];
                    end else begin
                        tbl_key[s] = k;
                        tbl_side[s] = 2'd1;
                        tbl_depth[s] = d;
                        tbl_alg[s] = dragon_code;
                        bump_count();
                        a.status = ST_NEW;
                    end
                end
            end
        end
        return a;
    endfunction

    // one request; valid stays high back to back unless the sender idles
    task automatic send_request(input logic [2:0] act, input logic [63:0] k,
                                input logic [15:0] d, input logic sd, input logic [7:0] al,
                                input logic sk, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {3'b0, sk, al, sd, d, k, act};
        s_axis_tlast <= lst;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_answers.push_back(apply_request(act, k, d, sd, al, sk, lst));
        n_requests++;
    endtask

    task automatic go_quiet();
        s_axis_tvalid <= 0;
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_code(input logic [7:0] v);
        go_quiet();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        dragon_code = v;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] key_at(input int slot, input logic [53:0] low);
        return {slot[LOGN-1:0], low};
    endfunction

    // receiver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                answer_t w;
                answer_t g;
                g = {m_axis_tlast, m_axis_tdata[21:0]};
                if (pending_answers.size() == 0) begin
                    errors++;
                    $display("unexpected result %0h", m_axis_tdata);
                end else begin
                    w = pending_answers.pop_front();
                    if (g.status != w.status) report("status", g.status, w.status);
                    if (g.hit != w.hit) report("hit", g.hit, w.hit);
                    if (g.depth != w.depth) report("depth_out", g.depth, w.depth);
                    if (g.mark != w.mark) report("mark", g.mark, w.mark);
                    if (g.done != w.done) report("batch_done", g.done, w.done);
                end
                n_results++;
            end
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        logic [63:0] k1;
        k1 = key_at(5, 54'h123);
        send_request(ACT_LOOKUP, k1, 16'd0, 0, 8'd0, 0, 0);
        send_request(ACT_INSERT, k1, 16'd100, 0, 8'd7, 0, 1);
        send_request(ACT_INSERT, k1, 16'd50, 0, 8'd9, 0, 0);
        send_request(ACT_INSERT, k1, 16'd80, 0, 8'd9, 0, 0);
        send_request(ACT_LOOKUP, k1, 16'd0, 1, 8'd0, 0, 0);
        send_request(ACT_INSERT, k1, 16'hFFFF, 1, 8'd254, 0, 0);
        send_request(ACT_INSERT, k1, 16'd1, 0, 8'd0, 0, 0);
        send_request(ACT_LOOKUP, k1, 16'd0, 1, 8'd0, 0, 1);
        send_request(ACT_MARK, k1, 16'd0, 0, 8'd0, 0, 0);
        send_request(ACT_UPDATE, k1, 16'd10, 0, 8'd0, 0, 0);
        send_request(ACT_MARK, k1, 16'd0, 0, 8'd0, 0, 0);
        send_request(ACT_INSERT, k1, 16'd0, 1, 8'd1, 0, 0);
        send_request(ACT_UPDATE, k1, 16'd0, 0, 8'd0, 1, 0);
        // colliding key on forward side, then dragonfly overwrite
        send_request(ACT_INSERT, key_at(5, 54'h7), 16'd4, 0, 8'd2, 0, 0);
        send_request(ACT_MARK, key_at(5, 54'h7), 16'd0, 0, 8'd0, 0, 0);
        send_request(ACT_UPDATE, key_at(5, 54'h7), 16'd3, 1, 8'd0, 0, 0);
        send_request(ACT_UPDATE, key_at(NSLOT - 1, 54'h3FFFFF_FFFFFFFF), 16'd2, 0, 8'd0, 0, 0);
        send_request(ACT_INSERT, key_at(NSLOT - 1, 54'h1), 16'd2, 1, 8'd255, 0, 0);
        send_request(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 1, 8'd0, 0, 0);
        send_request(ACT_INSERT, 64'd0, 16'd5, 0, 8'd0, 0, 0);
        send_request(ACT_LOOKUP, 64'd0, 16'd0, 0, 8'd0, 0, 0);
        send_request(ACT_MARK, 64'd0, 16'd0, 0, 8'd0, 0, 0);
        send_request(ACT_UPDATE, 64'd0, 16'd5, 0, 8'd0, 0, 0);
        send_request(3'd5, k1, 16'd0, 0, 8'd0, 0, 0);
        send_request(3'd7, k1, 16'd0, 0, 8'd0, 0, 1);
        send_request(ACT_CLEAR, 64'd0, 16'd0, 0, 8'd0, 0, 0);
    endtask

    // fill to half with inserts, refusals, then fill every slot with updates
    task automatic test_fill_and_exhaust();
        for (int i = 0; i < HALF + 3; i++)
            send_request(ACT_INSERT, key_at(i * 2, 54'h55), 16'(i), 0, 8'd1, 0, 0);
        for (int i = 0; i < NSLOT / 2; i++)
            send_request(ACT_UPDATE, key_at(i * 2 + 1, 54'hAA), 16'd9, 0, 8'd0, 0, 0);
        send_request(ACT_UPDATE, key_at(3, 54'h1), 16'd9, 0, 8'd0, 0, 0);
        send_request(ACT_LOOKUP, key_at(7, 54'h1), 16'd0, 1, 8'd0, 0, 0);
        send_request(ACT_MARK, key_at(6, 54'h55), 16'd0, 1, 8'd0, 0, 0);
        send_request(ACT_LOOKUP, key_at(9, 54'hAA), 16'd0, 1, 8'd0, 0, 1);
        send_request(ACT_CLEAR, 64'd0, 16'd0, 0, 8'd0, 0, 0);
    endtask

    // random traffic over a small key pool so entries are hit repeatedly
    task automatic test_random(input int n);
        logic [63:0] pool [24];
        logic [2:0] act;
        logic [63:0] k;
        for (int i = 0; i < 24; i++)
            pool[i] = {$urandom_range(15) == 0 ? 10'(NSLOT - 1) : 10'($urandom_range(7)),
                       6'($urandom), 16'($urandom), 32'($urandom)};
        for (int i = 0; i < n; i++) begin
            act = 3'($urandom_range(3));
            if ($urandom_range(199) == 0) act = ACT_CLEAR;
            else if ($urandom_range(99) == 0) act = 3'($urandom_range(7, 5));
            case ($urandom_range(19))
                0: k = 64'd0;
                1: k = {$urandom, $urandom};
                default: k = pool[$urandom_range(23)];
            endcase
            send_request(act, k, $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(31)),
                         1'($urandom), $urandom_range(3) == 0 ? dragon_code : 8'($urandom),
                         $urandom_range(4) == 0, 1'($urandom));
        end
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge aclk);
                recv_hold = 0;
            end
            test_random(40);
        join
    endtask

    initial begin
        wipe_table();
        dragon_code = DRAGONFLY_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        send_idle_pct = 29;
        recv_idle_pct = 79;
        test_directed();
        test_fill_and_exhaust();
        test_random(100);
        write_code(8'd0);
        send_idle_pct = 79;
        recv_idle_pct = 29;
        test_random(100);
        write_code(8'd254);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(30);
        write_code(8'd77);
        test_random(20);
        go_quiet();
        if (pending_answers.size() != 0) begin
            errors++;
            $display("%0d results never arrived", pending_answers.size());
        end
        $display("ran %0d requests and checked %0d results over %0d cycles", n_requests,
                 n_results, cycles);
        $display("covered all actions, half-full refusal, full table probing, stalls");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/sfht_pkg.sv
rtl/sfht_ram.sv
rtl/search_frontier_hash_table_unit.sv
dv/tb.sv
